// ===== rtl/heading_holdover_tracker_assert.svh =====
// -----------------------------------------------------------------------------
// Heading holdover tracker assertion macros
// Shared property forms for the tracker RTL. Each macro expects signals named
// clk and rst_n in the module that uses it.
// -----------------------------------------------------------------------------
`ifndef HEADING_HOLDOVER_TRACKER_ASSERT_SVH
`define HEADING_HOLDOVER_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HHT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HHT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hht_pkg.sv =====
// -----------------------------------------------------------------------------
// Heading holdover tracker package
// Types, codes and widths shared by the tracker and its arithmetic unit.
// -----------------------------------------------------------------------------
package hht_pkg;

    // Operating modes as reported on the result.
    localparam logic [1:0] MODE_TRACK = 2'd0;
    localparam logic [1:0] MODE_HOLD  = 2'd1;
    localparam logic [1:0] MODE_LOST  = 2'd2;

    // Quality code reported during holdover and blend.
    localparam logic [1:0] QUAL_POOR = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_HOLDOVER = 2'd0;
    localparam logic [1:0] CFG_MIN_GOOD     = 2'd1;
    localparam logic [1:0] CFG_BLEND_MS     = 2'd2;

    // Configuration reset values.
    localparam logic [23:0] MAX_HOLDOVER_RST = 24'd30000;
    localparam logic [7:0]  MIN_GOOD_RST     = 8'd3;
    localparam logic [15:0] BLEND_MS_RST     = 16'd2000;

    // Arithmetic unit widths and step counts.
    localparam int MCAND_W  = 32;
    localparam int MPLIER_W = 21;
    localparam int NUM_W    = 49;
    localparam int DEN_W    = 17;
    localparam int WORK_W   = MCAND_W + MPLIER_W;
    localparam int ADD_W    = MCAND_W + 2;
    localparam int CNT_W    = 6;
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MPLIER_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(NUM_W);

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_stat_t;

    // Sequencer states of the tracker.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_ADJUST,
        ST_FINISH
    } state_t;

    // Source of the new held angle.
    typedef enum logic [1:0] {
        SEL_KEEP,
        SEL_TARGET,
        SEL_DR,
        SEL_BLEND
    } held_sel_t;

endpackage

// ===== rtl/hht_arith.sv =====
// -----------------------------------------------------------------------------
// Heading holdover tracker arithmetic unit
// Serial shift-add multiplier and restoring divider sharing one adder.
// -----------------------------------------------------------------------------
`include "heading_holdover_tracker_assert.svh"

module hht_arith import hht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  arith_cmd_t          cmd,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    output arith_stat_t         stat,
    output logic [WORK_W-1:0]   result
);

    logic               busy_reg;
    logic               done_reg;
    arith_op_t          op_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WORK_W-1:0]  work_reg;
    logic [WORK_W-1:0]  work_next;
    logic [DEN_W:0]     rem_reg;
    logic [DEN_W:0]     rem_next;
    logic [MCAND_W-1:0] mcand_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DEN_W:0]     div_shift;
    logic [ADD_W-1:0]   add_a;
    logic [ADD_W-1:0]   add_b;
    logic               add_cin;
    logic [ADD_W-1:0]   add_sum;

    // Operand selection for the shared adder and the next work values.
    always_comb
    begin
        div_shift = {rem_reg[DEN_W-1:0], work_reg[NUM_W-1]};
        add_a     = '0;
        add_b     = '0;
        add_cin   = 1'b0;
        work_next = work_reg;
        rem_next  = rem_reg;
        unique case (op_reg)
            OP_MUL:
            begin
                add_a = {{(ADD_W-MCAND_W){1'b0}}, work_reg[WORK_W-1:MPLIER_W]};
                add_b = work_reg[0] ? {{(ADD_W-MCAND_W){1'b0}}, mcand_reg} : '0;
            end
            OP_DIV:
            begin
                add_a   = {{(ADD_W-DEN_W-1){1'b0}}, div_shift};
                add_b   = ~{{(ADD_W-DEN_W){1'b0}}, den_reg};
                add_cin = 1'b1;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
        add_sum = add_a + add_b + {{(ADD_W-1){1'b0}}, add_cin};
        if (op_reg == OP_MUL)
        begin
            work_next = {add_sum[MCAND_W:0], work_reg[MPLIER_W-1:1]};
        end
        else
        begin
            // A clear sign bit means the trial subtraction fits: quotient bit 1.
            work_next = {work_reg[WORK_W-1:NUM_W], work_reg[NUM_W-2:0], ~add_sum[ADD_W-1]};
            rem_next  = add_sum[ADD_W-1] ? div_shift : add_sum[DEN_W:0];
        end
    end

    // Step counter and handshake with the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= (cmd.op == OP_MUL) ? MUL_STEPS : DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg <= mcand;
            den_reg   <= den;
            rem_reg   <= '0;
            if (cmd.op == OP_MUL)
            begin
                work_reg <= {{MCAND_W{1'b0}}, mplier};
            end
            else
            begin
                work_reg <= {{(WORK_W-NUM_W){1'b0}}, num};
            end
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = work_reg;

    `HHT_ASSERT_IMP(a_start_idle, cmd.start, !busy_reg, "arith start while busy")
    `HHT_ASSERT_NXT(a_done_pulse, done_reg, !done_reg, "arith done held for two cycles")
    `HHT_ASSERT_IMP(a_cnt_live, busy_reg, cnt_reg != '0, "arith busy with empty step count")

endmodule

// ===== rtl/heading_holdover_tracker.sv =====
// -----------------------------------------------------------------------------
// Heading holdover tracker
// Supervises an external heading source with gyro dead reckoning in holdover
// and a shortest-arc blend on recovery.
// -----------------------------------------------------------------------------
// One request is processed at a time; sample_ready is high only while idle.
// A request that needs no arithmetic (tracking, snap, lost) passes from the
// decide step straight to the finish step. Dead reckoning runs the serial
// multiplier for 21 steps; a recovery blend adds the 49-step restoring
// divider after the multiplier. The finished result sits in an output register
// and the block returns to idle once that register is free; an output stall
// holds the block in its finish step. Angles are held as 32-bit fractions of
// a turn; configuration is written by index through cfg_we, cfg_index and
// cfg_data.
// -----------------------------------------------------------------------------
`include "heading_holdover_tracker_assert.svh"

module heading_holdover_tracker import hht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  logic               source_valid,
    input  logic [15:0]        source_heading,
    input  logic [1:0]         source_quality,
    input  logic signed [23:0] yaw_rate,
    input  logic [20:0]        step_time,
    input  logic [31:0]        now_ms,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               out_valid,
    output logic [15:0]        out_heading,
    output logic [1:0]         out_quality,
    output logic [1:0]         out_mode,
    output logic               gyro_only,
    output logic [31:0]        holdover_elapsed,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    // Sequencer and configuration.
    state_t      state_reg;
    state_t      state_next;
    logic [23:0] max_holdover_reg;
    logic [7:0]  min_good_reg;
    logic [15:0] blend_ms_reg;

    // Latched request.
    logic        src_valid_reg;
    logic [15:0] src_heading_reg;
    logic [1:0]  src_quality_reg;
    logic [23:0] yaw_rate_reg;
    logic [20:0] step_time_reg;
    logic [31:0] now_ms_reg;

    // Tracker state.
    logic [1:0]  mode_reg;
    logic [7:0]  good_count_reg;
    logic        recovering_reg;
    logic        ever_locked_reg;
    logic        from_holdover_reg;
    logic [31:0] held_angle_reg;
    logic [31:0] holdover_start_reg;
    logic [31:0] blend_start_reg;
    logic [31:0] blend_origin_reg;

    // Plan for the request in flight.
    held_sel_t   sel_reg;
    logic        sign_reg;
    logic [31:0] delta_reg;
    logic [31:0] delta_next;
    logic        pend_valid_reg;
    logic [1:0]  pend_quality_reg;
    logic [1:0]  pend_mode_reg;
    logic        pend_gyro_reg;
    logic [31:0] pend_elapsed_reg;

    // Result register.
    logic        result_valid_reg;
    logic        out_valid_reg;
    logic [15:0] out_heading_reg;
    logic [1:0]  out_quality_reg;
    logic [1:0]  out_mode_reg;
    logic        gyro_only_reg;
    logic [31:0] holdover_elapsed_reg;

    // Decision signals.
    logic [31:0]         target;
    logic [7:0]          dec_good;
    logic [1:0]          dec_mode;
    logic                dec_rec;
    logic                dec_ever;
    logic                dec_fh;
    logic [31:0]         dec_hs;
    logic [31:0]         dec_bs;
    logic [31:0]         dec_bo;
    held_sel_t           dec_sel;
    logic                dec_valid;
    logic [1:0]          dec_quality;
    logic [1:0]          dec_out_mode;
    logic                dec_gyro;
    logic [31:0]         dec_elapsed;
    logic                dec_sign;
    logic [MCAND_W-1:0]  dec_mcand;
    logic [MPLIER_W-1:0] dec_mplier;
    logic [31:0]         hold_el;
    logic [31:0]         blend_el;
    logic [31:0]         blend_diff;
    logic [31:0]         blend_mag;
    logic [23:0]         rate_mag;

    // Arithmetic unit connection.
    arith_cmd_t          arith_cmd;
    arith_stat_t         arith_stat;
    logic [WORK_W-1:0]   arith_result;
    logic [NUM_W-1:0]    div_num;

    // Adjust and finish datapath.
    logic [35:0] dr_sum;
    logic [31:0] blend_q;
    logic [31:0] held_new;
    logic [15:0] heading_new;
    logic        out_free;
    logic        load_result;

    assign target = {src_heading_reg, 16'h0000};

    // Mode decision for the latched request.
    always_comb
    begin
        dec_good     = good_count_reg;
        dec_mode     = mode_reg;
        dec_rec      = recovering_reg;
        dec_ever     = ever_locked_reg;
        dec_fh       = from_holdover_reg;
        dec_hs       = holdover_start_reg;
        dec_bs       = blend_start_reg;
        dec_bo       = blend_origin_reg;
        dec_sel      = SEL_KEEP;
        dec_valid    = 1'b0;
        dec_quality  = 2'd0;
        dec_out_mode = MODE_LOST;
        dec_gyro     = 1'b0;
        dec_elapsed  = '0;
        if (!src_valid_reg)
        begin
            dec_good = '0;
            dec_rec  = 1'b0;
            if (mode_reg == MODE_TRACK)
            begin
                dec_mode = MODE_HOLD;
                dec_hs   = now_ms_reg;
            end
            if (dec_mode == MODE_HOLD)
            begin
                if (hold_el > {8'h00, max_holdover_reg})
                begin
                    dec_mode = MODE_LOST;
                end
                else
                begin
                    dec_sel      = SEL_DR;
                    dec_valid    = 1'b1;
                    dec_quality  = QUAL_POOR;
                    dec_out_mode = MODE_HOLD;
                    dec_gyro     = 1'b1;
                    dec_elapsed  = hold_el;
                end
            end
        end
        else
        begin
            dec_good = (good_count_reg == 8'hFF) ? 8'hFF : good_count_reg + 8'd1;
            if (mode_reg == MODE_TRACK || !ever_locked_reg)
            begin
                dec_mode     = MODE_TRACK;
                dec_ever     = 1'b1;
                dec_sel      = SEL_TARGET;
                dec_valid    = 1'b1;
                dec_quality  = src_quality_reg;
                dec_out_mode = MODE_TRACK;
            end
            else if (dec_good < min_good_reg)
            begin
                if (mode_reg == MODE_HOLD)
                begin
                    dec_sel      = SEL_DR;
                    dec_valid    = 1'b1;
                    dec_quality  = QUAL_POOR;
                    dec_out_mode = MODE_HOLD;
                    dec_gyro     = 1'b1;
                end
            end
            else
            begin
                // First trusted sample opens the recovery window.
                if (!recovering_reg)
                begin
                    dec_rec = 1'b1;
                    dec_bs  = now_ms_reg;
                    dec_bo  = held_angle_reg;
                    dec_fh  = (mode_reg == MODE_HOLD);
                end
                if (!dec_fh || blend_ms_reg == 16'd0 || blend_el >= {16'h0000, blend_ms_reg})
                begin
                    dec_mode     = MODE_TRACK;
                    dec_rec      = 1'b0;
                    dec_sel      = SEL_TARGET;
                    dec_valid    = 1'b1;
                    dec_quality  = src_quality_reg;
                    dec_out_mode = MODE_TRACK;
                end
                else
                begin
                    dec_sel      = SEL_BLEND;
                    dec_valid    = 1'b1;
                    dec_quality  = QUAL_POOR;
                    dec_out_mode = MODE_HOLD;
                end
            end
        end
    end

    // Elapsed times and multiplier operands.
    always_comb
    begin
        hold_el    = now_ms_reg - ((mode_reg == MODE_TRACK) ? now_ms_reg : holdover_start_reg);
        blend_el   = now_ms_reg - (recovering_reg ? blend_start_reg : now_ms_reg);
        blend_diff = target - (recovering_reg ? blend_origin_reg : held_angle_reg);
        blend_mag  = blend_diff[31] ? (~blend_diff + 32'd1) : blend_diff;
        rate_mag   = yaw_rate_reg[23] ? (~yaw_rate_reg + 24'd1) : yaw_rate_reg;
        if (dec_sel == SEL_DR)
        begin
            dec_sign   = yaw_rate_reg[23];
            dec_mcand  = {{(MCAND_W-24){1'b0}}, rate_mag};
            dec_mplier = step_time_reg;
        end
        else
        begin
            dec_sign   = blend_diff[31];
            dec_mcand  = blend_mag;
            dec_mplier = {{(MPLIER_W-16){1'b0}}, blend_el[15:0]};
        end
    end

    // Rounding numerator for the blend step: 2 * product + duration.
    assign div_num = {arith_result[NUM_W-2:0], 1'b0} + {{(NUM_W-16){1'b0}}, blend_ms_reg};

    hht_arith u_arith
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (arith_cmd),
        .mcand  (dec_mcand),
        .mplier (dec_mplier),
        .num    (div_num),
        .den    ({blend_ms_reg, 1'b0}),
        .stat   (arith_stat),
        .result (arith_result)
    );

    // Step delta: rounded dead-reckoning increment or signed blend step.
    always_comb
    begin
        dr_sum  = sign_reg ? (36'd8 - arith_result[35:0]) : (arith_result[35:0] + 36'd8);
        blend_q = arith_result[31:0];
        if (sel_reg == SEL_DR)
        begin
            delta_next = dr_sum[35:4];
        end
        else
        begin
            delta_next = sign_reg ? (~blend_q + 32'd1) : blend_q;
        end
    end

    // New held angle and its rounded 16-bit heading.
    always_comb
    begin
        case (sel_reg)
            SEL_TARGET: held_new = target;
            SEL_DR:     held_new = held_angle_reg + delta_reg;
            SEL_BLEND:  held_new = blend_origin_reg + delta_reg;
            default:    held_new = held_angle_reg;
        endcase
        heading_new = pend_valid_reg ? (held_new[31:16] + {15'h0000, held_new[15]}) : 16'h0000;
    end

    assign out_free = !result_valid_reg || result_ready;

    // Sequencer next state and controls.
    always_comb
    begin
        state_next      = state_reg;
        sample_ready    = 1'b0;
        arith_cmd.start = 1'b0;
        arith_cmd.op    = OP_MUL;
        load_result     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (dec_sel == SEL_DR || dec_sel == SEL_BLEND)
                begin
                    arith_cmd.start = 1'b1;
                    state_next      = ST_MUL;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL:
            begin
                if (arith_stat.done)
                begin
                    if (sel_reg == SEL_BLEND)
                    begin
                        arith_cmd.start = 1'b1;
                        arith_cmd.op    = OP_DIV;
                        state_next      = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_ADJUST;
                    end
                end
            end
            ST_DIV:
            begin
                if (arith_stat.done)
                begin
                    state_next = ST_ADJUST;
                end
            end
            ST_ADJUST:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_holdover_reg <= MAX_HOLDOVER_RST;
            min_good_reg     <= MIN_GOOD_RST;
            blend_ms_reg     <= BLEND_MS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_HOLDOVER: max_holdover_reg <= cfg_data;
                CFG_MIN_GOOD:     min_good_reg     <= cfg_data[7:0];
                CFG_BLEND_MS:     blend_ms_reg     <= cfg_data[15:0];
                default:          min_good_reg     <= min_good_reg;
            endcase
        end
    end

    // Tracker state: committed at decision, held angle at finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_LOST;
            good_count_reg     <= '0;
            recovering_reg     <= 1'b0;
            ever_locked_reg    <= 1'b0;
            from_holdover_reg  <= 1'b0;
            held_angle_reg     <= '0;
            holdover_start_reg <= '0;
            blend_start_reg    <= '0;
            blend_origin_reg   <= '0;
        end
        else
        begin
            if (state_reg == ST_DECIDE)
            begin
                mode_reg           <= dec_mode;
                good_count_reg     <= dec_good;
                recovering_reg     <= dec_rec;
                ever_locked_reg    <= dec_ever;
                from_holdover_reg  <= dec_fh;
                holdover_start_reg <= dec_hs;
                blend_start_reg    <= dec_bs;
                blend_origin_reg   <= dec_bo;
            end
            if (load_result)
            begin
                held_angle_reg <= held_new;
            end
        end
    end

    // Request latch, plan and delta registers.
    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            src_valid_reg   <= source_valid;
            src_heading_reg <= source_heading;
            src_quality_reg <= source_quality;
            yaw_rate_reg    <= yaw_rate;
            step_time_reg   <= step_time;
            now_ms_reg      <= now_ms;
        end
        if (state_reg == ST_DECIDE)
        begin
            sel_reg          <= dec_sel;
            sign_reg         <= dec_sign;
            pend_valid_reg   <= dec_valid;
            pend_quality_reg <= dec_quality;
            pend_mode_reg    <= dec_out_mode;
            pend_gyro_reg    <= dec_gyro;
            pend_elapsed_reg <= dec_elapsed;
        end
        if (state_reg == ST_ADJUST)
        begin
            delta_reg <= delta_next;
        end
    end

    // Output handshake flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_valid_reg        <= pend_valid_reg;
            out_heading_reg      <= heading_new;
            out_quality_reg      <= pend_quality_reg;
            out_mode_reg         <= pend_mode_reg;
            gyro_only_reg        <= pend_gyro_reg;
            holdover_elapsed_reg <= pend_elapsed_reg;
        end
    end

    assign result_valid     = result_valid_reg;
    assign out_valid        = out_valid_reg;
    assign out_heading      = out_heading_reg;
    assign out_quality      = out_quality_reg;
    assign out_mode         = out_mode_reg;
    assign gyro_only        = gyro_only_reg;
    assign holdover_elapsed = holdover_elapsed_reg;

    `HHT_ASSERT_IMP(a_load_from_finish, $rose(result_valid_reg), $past(state_reg == ST_FINISH), "result loaded outside finish")
    `HHT_ASSERT_IMP(a_invalid_zero, result_valid_reg && !out_valid_reg, out_mode_reg == MODE_LOST && out_heading_reg == '0 && holdover_elapsed_reg == '0, "invalid result carries data")
    `HHT_ASSERT_IMP(a_gyro_hold, result_valid_reg && gyro_only_reg, out_mode_reg == MODE_HOLD && out_valid_reg, "gyro only outside holdover")

endmodule
